// ===== sv/dpc_pkg.sv =====
`default_nettype none

package dpc_pkg;

    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 20;
    localparam int DUR_W      = 23;
    localparam int COUNT_W    = 32;
    localparam int LED_W      = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 64;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET    = DEBOUNCE_W'(50000);
    localparam logic [DUR_W-1:0]      SHORT_LIMIT_RESET = DUR_W'(200);
    localparam logic [DUR_W-1:0]      LONG_LIMIT_RESET  = DUR_W'(1000);

    // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT holds exactly for every 32-bit x.
    localparam int DIV_SHIFT = 38;
    localparam int MAGIC_W   = 29;
    localparam int PROD_W    = TIME_W + MAGIC_W;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(274877907);

    typedef enum logic [1:0]
    {
        REG_DEBOUNCE    = 2'd0,
        REG_SHORT_LIMIT = 2'd1,
        REG_LONG_LIMIT  = 2'd2
    } reg_index_t;

    typedef enum logic [LED_W-1:0]
    {
        LED_NONE  = 2'd0,
        LED_RED   = 2'd1,
        LED_GREEN = 2'd2,
        LED_BLUE  = 2'd3
    } led_t;

    typedef enum logic
    {
        EDGE_PRESS   = 1'b0,
        EDGE_RELEASE = 1'b1
    } edge_kind_t;

    typedef struct packed
    {
        logic [DEBOUNCE_W-1:0] debounce_us;
        logic [DUR_W-1:0]      short_limit_ms;
        logic [DUR_W-1:0]      long_limit_ms;
    } cfg_t;

    typedef struct packed
    {
        logic              valid;
        edge_kind_t        opcode;
        logic [TIME_W-1:0] time_us;
    } edge_beat_t;

    function automatic logic [DUR_W-1:0] us_to_ms(input logic [TIME_W-1:0] us);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(us) * PROD_W'(DIV_MAGIC);
        return prod[DIV_SHIFT +: DUR_W];
    endfunction

endpackage

`default_nettype wire

// ===== sv/dpc_cfg_regs.sv =====
`default_nettype none

module dpc_cfg_regs
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [dpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output dpc_pkg::cfg_t                         cfg
);

    import dpc_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       write_en;

    assign pready   = 1'b1;
    assign index    = reg_index_t'(paddr[3:2]);
    assign write_en = psel && penable && pwrite && pready;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_us    <= DEBOUNCE_RESET;
            cfg_reg.short_limit_ms <= SHORT_LIMIT_RESET;
            cfg_reg.long_limit_ms  <= LONG_LIMIT_RESET;
        end
        else if (write_en)
        begin
            case (index)
                REG_DEBOUNCE:    cfg_reg.debounce_us    <= pwdata[DEBOUNCE_W-1:0];
                REG_SHORT_LIMIT: cfg_reg.short_limit_ms <= pwdata[DUR_W-1:0];
                REG_LONG_LIMIT:  cfg_reg.long_limit_ms  <= pwdata[DUR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_DEBOUNCE:    prdata = APB_DATA_W'(cfg_reg.debounce_us);
            REG_SHORT_LIMIT: prdata = APB_DATA_W'(cfg_reg.short_limit_ms);
            REG_LONG_LIMIT:  prdata = APB_DATA_W'(cfg_reg.long_limit_ms);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/dpc_in_stage.sv =====
`default_nettype none

module dpc_in_stage
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dpc_pkg::TIME_W-1:0]     s_time_us,
    input  wire logic                           s_opcode,
    input  wire logic                           advance,
    output dpc_pkg::edge_beat_t                 beat
);

    import dpc_pkg::*;

    edge_beat_t beat_reg;
    edge_beat_t beat_next;

    // The held beat leaves whenever the result stage can take it.
    assign s_tready = !beat_reg.valid || advance;
    assign beat     = beat_reg;

    always_comb
    begin
        beat_next = beat_reg;
        if (s_tready)
        begin
            beat_next.valid   = s_tvalid;
            beat_next.opcode  = edge_kind_t'(s_opcode);
            beat_next.time_us = s_time_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dpc_core.sv =====
`default_nettype none

module dpc_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dpc_pkg::cfg_t                  cfg,
    input  wire dpc_pkg::edge_beat_t            beat,
    output logic                                advance,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic                                m_press_done,
    output logic [dpc_pkg::LED_W-1:0]           m_led_color,
    output logic [dpc_pkg::DUR_W-1:0]           m_hold_ms,
    output logic [dpc_pkg::COUNT_W-1:0]         m_press_total
);

    import dpc_pkg::*;

    logic [TIME_W-1:0]  last_edge_reg,  last_edge_next;
    logic [TIME_W-1:0]  press_start_reg, press_start_next;
    logic               armed_reg,      armed_next;
    logic [COUNT_W-1:0] counter_reg,    counter_next;
    led_t               led_reg,        led_next;
    logic [DUR_W-1:0]   duration_reg,   duration_next;
    logic               done_reg,       done_next;
    logic               out_valid_reg,  out_valid_next;

    logic               take;
    logic [TIME_W-1:0]  gap;
    logic [TIME_W-1:0]  held_us;
    logic [DUR_W-1:0]   dur_ms;

    assign advance = !out_valid_reg || m_tready;
    assign take    = beat.valid && advance;
    assign gap     = beat.time_us - last_edge_reg;
    assign held_us = beat.time_us - press_start_reg;
    assign dur_ms  = us_to_ms(held_us);

    always_comb
    begin
        last_edge_next   = last_edge_reg;
        press_start_next = press_start_reg;
        armed_next       = armed_reg;
        counter_next     = counter_reg;
        led_next         = led_reg;
        duration_next    = duration_reg;
        done_next        = done_reg;
        out_valid_next   = out_valid_reg;

        if (advance)
        begin
            out_valid_next = beat.valid;
        end

        if (take)
        begin
            done_next = 1'b0;
            if (gap >= TIME_W'(cfg.debounce_us))
            begin
                last_edge_next = beat.time_us;
                if (beat.opcode == EDGE_PRESS)
                begin
                    press_start_next = beat.time_us;
                    armed_next       = 1'b1;
                end
                else if (armed_reg)
                begin
                    armed_next    = 1'b0;
                    duration_next = dur_ms;
                    done_next     = 1'b1;
                    if (dur_ms < cfg.short_limit_ms)
                    begin
                        led_next = LED_RED;
                    end
                    else
                    begin
                        led_next     = (dur_ms <= cfg.long_limit_ms) ? LED_GREEN : LED_BLUE;
                        counter_next = counter_reg + COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg   <= '0;
            press_start_reg <= '0;
            armed_reg       <= 1'b0;
            counter_reg     <= '0;
            led_reg         <= LED_NONE;
            duration_reg    <= '0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            last_edge_reg   <= last_edge_next;
            press_start_reg <= press_start_next;
            armed_reg       <= armed_next;
            counter_reg     <= counter_next;
            led_reg         <= led_next;
            duration_reg    <= duration_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // The outputs are driven straight from the state registers.
    assign m_tvalid      = out_valid_reg;
    assign m_press_done  = done_reg;
    assign m_led_color   = led_reg;
    assign m_hold_ms     = duration_reg;
    assign m_press_total = counter_reg;

    a_counter_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(counter_reg))
        else $error("press counter changed without a processed beat");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && done_next && led_next != LED_RED)
        |=> counter_reg == $past(counter_reg) + COUNT_W'(1))
        else $error("press counter did not step on a counted press");

    a_unarmed_release: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !armed_reg && beat.opcode == EDGE_RELEASE) |=> !done_reg)
        else $error("release without an armed press reported as done");

    a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (take && done_next) |=> (!armed_reg && last_edge_reg == $past(beat.time_us)))
        else $error("completed press left the block armed");

endmodule

`default_nettype wire

// ===== sv/debounced_press_classifier.sv =====
`default_nettype none

// Debounced press classifier: each input beat is one timestamped button edge
// (tuser 0 press, 1 release; tdata the microsecond timestamp), and every beat
// produces exactly one result beat holding the press-done flag, the lit LED,
// the last press duration in milliseconds and the count of green and blue
// presses. The block accepts one beat per clock cycle while m_tready does not
// stall the output; an accepted beat is registered in the input stage and its
// result in the result stage. The rate is set by the update of the last-edge
// time and armed state in the result stage, which also does the microsecond to
// millisecond division by a constant multiply. Configuration registers sit on
// the APB port at byte addresses 0 (debounce_us), 4 (short_limit_ms) and 8
// (long_limit_ms) and should only be written while no beat is in flight.
module debounced_press_classifier
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [dpc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [dpc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: time_us[31:0].
    input  wire logic [dpc_pkg::TDATA_IN_W-1:0]     s_tdata,
    // Fields from bit 0: opcode[0].
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // Fields from bit 0: led_color[1:0], hold_ms[24:2],
    // press_total[56:25], zero fill[63:57].
    output logic      [dpc_pkg::TDATA_OUT_W-1:0]    m_tdata,
    // Fields from bit 0: press_done[0].
    output logic                                    m_tuser
);

    import dpc_pkg::*;

    cfg_t               cfg;
    edge_beat_t         beat;
    logic               advance;
    logic [LED_W-1:0]   led_color;
    logic [DUR_W-1:0]   hold_ms;
    logic [COUNT_W-1:0] press_total;

    dpc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpc_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_time_us (s_tdata[TIME_W-1:0]),
        .s_opcode  (s_tuser),
        .advance   (advance),
        .beat      (beat)
    );

    dpc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .beat          (beat),
        .advance       (advance),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_press_done  (m_tuser),
        .m_led_color   (led_color),
        .m_hold_ms     (hold_ms),
        .m_press_total (press_total)
    );

    assign m_tdata = {(TDATA_OUT_W - LED_W - DUR_W - COUNT_W)'(0),
                      press_total, hold_ms, led_color};

endmodule

`default_nettype wire
